FILE: rtl/core/accumulator_machine_execute_top_macros.svh
// assertion macros shared by the accumulator machine rtl
`ifndef ACCUMULATOR_MACHINE_EXECUTE_TOP_MACROS_SVH
`define ACCUMULATOR_MACHINE_EXECUTE_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define AME_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define AME_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/ame_pkg.sv
// shared constants and types for the accumulator machine execute block
`timescale 1ns / 1ps

package ame_pkg;

  // widths fixed by the instruction and result formats
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 10;
  localparam int OP_W        = 4;
  localparam int CAUSE_W     = 2;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 80;

  // default data memory depth
  localparam int MEM_WORDS_DEF = 1024;

  // divider steps, one quotient bit each
  localparam int DIV_STEPS = DATA_W;

  // instruction lengths in words
  localparam logic [ADDR_W-1:0] INSTR_LEN_2 = ADDR_W'(2);
  localparam logic [ADDR_W-1:0] INSTR_LEN_3 = ADDR_W'(3);

  // opcodes
  localparam logic [OP_W-1:0] OP_ADD    = 4'd1;
  localparam logic [OP_W-1:0] OP_SUB    = 4'd2;
  localparam logic [OP_W-1:0] OP_MUL    = 4'd3;
  localparam logic [OP_W-1:0] OP_DIV    = 4'd4;
  localparam logic [OP_W-1:0] OP_JMP    = 4'd5;
  localparam logic [OP_W-1:0] OP_JMPN   = 4'd6;
  localparam logic [OP_W-1:0] OP_JMPP   = 4'd7;
  localparam logic [OP_W-1:0] OP_JMPZ   = 4'd8;
  localparam logic [OP_W-1:0] OP_COPY   = 4'd9;
  localparam logic [OP_W-1:0] OP_LOAD   = 4'd10;
  localparam logic [OP_W-1:0] OP_STORE  = 4'd11;
  localparam logic [OP_W-1:0] OP_INPUT  = 4'd12;
  localparam logic [OP_W-1:0] OP_OUTPUT = 4'd13;
  localparam logic [OP_W-1:0] OP_STOP   = 4'd14;

  // halt causes
  localparam logic [CAUSE_W-1:0] CAUSE_NONE    = 2'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_STOP    = 2'd1;
  localparam logic [CAUSE_W-1:0] CAUSE_DIVZERO = 2'd2;
  localparam logic [CAUSE_W-1:0] CAUSE_INVALID = 2'd3;

  // divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: rtl/core/accumulator_machine_execute_top.sv
// Accumulator machine execute unit: takes one instruction request at a time on the in_ stream,
// reads its operand word from the on-chip data memory, updates the accumulator, program
// counter and data memory, and returns one result request on the out_ stream. An ordinary
// instruction goes from acceptance to the result register through accept and memory read,
// execute and result load; DIV adds a wait for the one-bit-a-cycle divider. The result
// register lets the next request be accepted while a result still waits for out_tready.
// After reset the data memory is cleared one word a cycle and in_tready stays low until all
// MEM_WORDS words (1024 by default) are clear. Once STOP, a divide by zero or an invalid
// opcode halts the machine, every later request returns the held state with halted set.
`timescale 1ns / 1ps

`include "accumulator_machine_execute_top_macros.svh"

module accumulator_machine_execute_top #(
  parameter int MEM_WORDS = ame_pkg::MEM_WORDS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // req_type[3:0], first_address[13:4], second_address[23:14], input_value[55:24]
  input  logic [ame_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // next_pc[9:0], halted[10], halt_cause[12:11], output_valid[13],
  // output_value[45:14], accumulator_value[77:46], zero fill[79:78]
  output logic [ame_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready
);

  localparam int W  = ame_pkg::DATA_W;
  localparam int AW = $clog2(MEM_WORDS);

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0] state_r, state_nxt;

  // architectural state
  logic [W-1:0]                    acc_r, acc_nxt;
  logic [ame_pkg::ADDR_W-1:0]      pc_r, pc_nxt;
  logic                            halted_r, halted_nxt;
  logic [ame_pkg::CAUSE_W-1:0]     cause_r, cause_nxt;

  // latched request
  logic [ame_pkg::OP_W-1:0]        op_r;
  logic [ame_pkg::ADDR_W-1:0]      a1_r, a2_r;
  logic [W-1:0]                    ival_r;
  logic                            a1_ok_r;

  // result fields of the current instruction
  logic                            ov_r, ov_nxt;
  logic [W-1:0]                    oval_r, oval_nxt;

  // output register
  logic [ame_pkg::OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic                            out_tvalid_r, out_tvalid_nxt;

  // request fields
  logic [ame_pkg::OP_W-1:0]        in_op;
  logic [ame_pkg::ADDR_W-1:0]      in_a1, in_a2;
  logic [W-1:0]                    in_ival;
  logic                            in_accept;
  logic                            out_free;

  // memory and divider hookup
  logic [W-1:0]                    rd_data;
  logic                            wr_en;
  logic [AW-1:0]                   wr_addr;
  logic [W-1:0]                    wr_data;
  logic                            clr_busy;
  logic                            div_start;
  logic [W-1:0]                    div_quo;
  ame_pkg::div_stat_t              div_stat;

  // execute-stage helpers
  logic [W-1:0]                    m_word;
  logic                            a2_ok;
  logic [ame_pkg::ADDR_W-1:0]      pc_plus2, pc_plus3;

  // unpack the instruction request
  assign in_op     = in_tdata[3:0];
  assign in_a1     = in_tdata[13:4];
  assign in_a2     = in_tdata[23:14];
  assign in_ival   = in_tdata[55:24];
  assign in_tready = (state_r == ST_IDLE) && !clr_busy;
  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  ame_dmem #(
    .MEM_WORDS (MEM_WORDS),
    .AW        (AW)
  ) u_dmem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_accept),
    .rd_addr  (AW'(in_a1)),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .clr_busy (clr_busy)
  );

  ame_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_r),
    .divisor  (m_word),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  // latch the request alongside the memory read
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r    <= in_op;
      a1_r    <= in_a1;
      a2_r    <= in_a2;
      ival_r  <= in_ival;
      a1_ok_r <= 32'(in_a1) < 32'(MEM_WORDS);
    end
  end

  // operand word, zero beyond the memory
  assign m_word   = a1_ok_r ? rd_data : '0;
  assign a2_ok    = 32'(a2_r) < 32'(MEM_WORDS);
  assign pc_plus2 = pc_r + ame_pkg::INSTR_LEN_2;
  assign pc_plus3 = pc_r + ame_pkg::INSTR_LEN_3;

  // execute, divide completion and result load
  always_comb begin
    state_nxt      = state_r;
    acc_nxt        = acc_r;
    pc_nxt         = pc_r;
    halted_nxt     = halted_r;
    cause_nxt      = cause_r;
    ov_nxt         = ov_r;
    oval_nxt       = oval_r;
    out_tdata_nxt  = out_tdata_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    wr_en          = 1'b0;
    wr_addr        = AW'(a1_r);
    wr_data        = acc_r;
    div_start      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ov_nxt    = 1'b0;
        oval_nxt  = '0;
        state_nxt = ST_FIN;
        if (!halted_r) begin
          pc_nxt = pc_plus2;
          case (op_r)
            ame_pkg::OP_ADD: acc_nxt = acc_r + m_word;
            ame_pkg::OP_SUB: acc_nxt = acc_r - m_word;
            ame_pkg::OP_MUL: acc_nxt = W'(acc_r * m_word);
            ame_pkg::OP_DIV: begin
              if (m_word == '0) begin
                pc_nxt     = pc_r;
                halted_nxt = 1'b1;
                cause_nxt  = ame_pkg::CAUSE_DIVZERO;
              end else begin
                pc_nxt    = pc_r;
                div_start = 1'b1;
                state_nxt = ST_DIV;
              end
            end
            ame_pkg::OP_JMP: pc_nxt = a1_r;
            ame_pkg::OP_JMPN: begin
              if (acc_r[W-1]) begin
                pc_nxt = a1_r;
              end
            end
            ame_pkg::OP_JMPP: begin
              if (!acc_r[W-1] && (acc_r != '0)) begin
                pc_nxt = a1_r;
              end
            end
            ame_pkg::OP_JMPZ: begin
              if (acc_r == '0) begin
                pc_nxt = a1_r;
              end
            end
            ame_pkg::OP_COPY: begin
              wr_en   = a2_ok;
              wr_addr = AW'(a2_r);
              wr_data = m_word;
              pc_nxt  = pc_plus3;
            end
            ame_pkg::OP_LOAD: acc_nxt = m_word;
            ame_pkg::OP_STORE: begin
              wr_en   = a1_ok_r;
              wr_data = acc_r;
            end
            ame_pkg::OP_INPUT: begin
              wr_en   = a1_ok_r;
              wr_data = ival_r;
            end
            ame_pkg::OP_OUTPUT: begin
              ov_nxt   = 1'b1;
              oval_nxt = m_word;
            end
            ame_pkg::OP_STOP: begin
              pc_nxt     = pc_r;
              halted_nxt = 1'b1;
              cause_nxt  = ame_pkg::CAUSE_STOP;
            end
            default: begin
              pc_nxt     = pc_r;
              halted_nxt = 1'b1;
              cause_nxt  = ame_pkg::CAUSE_INVALID;
            end
          endcase
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          acc_nxt   = div_quo;
          pc_nxt    = pc_plus2;
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_tdata_nxt  = {2'b00, acc_r, oval_r, ov_r, cause_r, halted_r, pc_r};
          out_tvalid_nxt = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control and architectural registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      acc_r        <= '0;
      pc_r         <= '0;
      halted_r     <= 1'b0;
      cause_r      <= ame_pkg::CAUSE_NONE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      acc_r        <= acc_nxt;
      pc_r         <= pc_nxt;
      halted_r     <= halted_nxt;
      cause_r      <= cause_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ov_r        <= ov_nxt;
    oval_r      <= oval_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign out_tdata  = out_tdata_r;
  assign out_tvalid = out_tvalid_r;

  // checks
  `AME_ASSERT_NOW(a_no_req_while_clearing, clr_busy, !in_tready, "request taken during memory clear")
  `AME_ASSERT_NEXT(a_halt_sticky, halted_r, halted_r, "halted flag dropped")
  `AME_ASSERT_NOW(a_halt_has_cause, halted_r, cause_r != ame_pkg::CAUSE_NONE, "halt without cause")
  `AME_ASSERT_NOW(a_write_in_exec, wr_en, (state_r == ST_EXEC) && !halted_r, "stray memory write")
  `AME_ASSERT_NOW(a_div_done_in_div, div_stat.done, state_r == ST_DIV, "divider done outside divide")
  `AME_ASSERT_NOW(a_div_start_idle, div_start, !div_stat.busy, "divide started while busy")

endmodule

FILE: rtl/core/ame_dmem.sv
// data memory with one read and one write port and a clearing sweep after reset
`timescale 1ns / 1ps

module ame_dmem #(
  parameter int MEM_WORDS = ame_pkg::MEM_WORDS_DEF,
  parameter int AW        = $clog2(MEM_WORDS)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [ame_pkg::DATA_W-1:0] rd_data,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [ame_pkg::DATA_W-1:0] wr_data,
  output logic                      clr_busy
);

  logic [ame_pkg::DATA_W-1:0] mem [MEM_WORDS];
  logic [ame_pkg::DATA_W-1:0] rd_data_r;
  logic [AW-1:0]              clr_idx_r, clr_idx_nxt;
  logic                       clr_busy_r, clr_busy_nxt;

  // clearing sweep, one word a cycle
  always_comb begin
    clr_idx_nxt  = clr_idx_r;
    clr_busy_nxt = clr_busy_r;
    if (clr_busy_r) begin
      clr_idx_nxt = clr_idx_r + AW'(1);
      if (clr_idx_r == AW'(MEM_WORDS - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r  <= '0;
      clr_busy_r <= 1'b1;
    end else begin
      clr_idx_r  <= clr_idx_nxt;
      clr_busy_r <= clr_busy_nxt;
    end
  end

  // write port, shared by the sweep
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_idx_r] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign clr_busy = clr_busy_r;

endmodule

FILE: rtl/core/ame_div.sv
// signed restoring divider, one quotient bit a cycle, truncates toward zero
`timescale 1ns / 1ps

module ame_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ame_pkg::DATA_W-1:0] dividend,
  input  logic [ame_pkg::DATA_W-1:0] divisor,
  output logic [ame_pkg::DATA_W-1:0] quotient,
  output ame_pkg::div_stat_t         stat
);

  localparam int W  = ame_pkg::DATA_W;
  localparam int CW = $clog2(ame_pkg::DIV_STEPS);

  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  dvs_r, dvs_nxt;
  logic          neg_r, neg_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    shifted;
  logic          fits;

  // one restoring step: shift in the next dividend bit and try to subtract
  assign shifted = {rem_r, quo_r[W-1]};
  assign fits    = shifted >= {1'b0, dvs_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      // operate on magnitudes, fix the sign at the end
      quo_nxt  = dividend[W-1] ? (W'(0) - dividend) : dividend;
      dvs_nxt  = divisor[W-1] ? (W'(0) - divisor) : divisor;
      neg_nxt  = dividend[W-1] ^ divisor[W-1];
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? W'(shifted - {1'b0, dvs_r}) : shifted[W-1:0];
      quo_nxt = {quo_r[W-2:0], fits};
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(ame_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
  end

  // sign fix on the finished magnitude
  assign quotient  = neg_r ? (W'(0) - quo_r) : quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

FILE: tb/accumulator_machine_execute_top_tb.sv
// self-checking stream testbench for the accumulator machine execute unit
`timescale 1ns / 1ps

module accumulator_machine_execute_top_tb;

  // opcodes outside the instruction set
  localparam logic [ame_pkg::OP_W-1:0] OP_BAD_LOW  = 4'd0;
  localparam logic [ame_pkg::OP_W-1:0] OP_BAD_HIGH = 4'd15;

  // halt scenario picked for the closing test
  localparam int HALT_BY_STOP     = 0;
  localparam int HALT_BY_DIVZERO  = 1;
  localparam int HALT_BY_BAD_LOW  = 2;
  localparam int HALT_BY_BAD_HIGH = 3;

  localparam int WATCHDOG_LIMIT = 10000;
  localparam int LONG_HOLD      = 400;
  localparam int DRAIN_CYCLES   = 60;

  typedef struct {
    logic [ame_pkg::ADDR_W-1:0]  next_pc;
    logic                        halted;
    logic [ame_pkg::CAUSE_W-1:0] cause;
    logic                        ovalid;
    logic [ame_pkg::DATA_W-1:0]  oval;
    logic [ame_pkg::DATA_W-1:0]  acc;
  } exec_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic [ame_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [ame_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;

  // machine state as predicted
  logic [ame_pkg::DATA_W-1:0]  acc_m;
  logic [ame_pkg::ADDR_W-1:0]  pc_m;
  logic                        halted_m;
  logic [ame_pkg::CAUSE_W-1:0] cause_m;
  logic [ame_pkg::DATA_W-1:0]  mem_m [0:ame_pkg::MEM_WORDS_DEF-1];

  exec_result_t pending_results[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req_cnt  = 0;
  int err_count     = 0;
  int instr_count   = 0;
  int result_count  = 0;
  int div_count     = 0;
  int jump_count    = 0;
  string halt_name  = "none";

  accumulator_machine_execute_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // executes one instruction on the predicted state and queues its result
  task automatic execute_model(input logic [ame_pkg::OP_W-1:0] op,
                               input logic [ame_pkg::ADDR_W-1:0] a1,
                               input logic [ame_pkg::ADDR_W-1:0] a2,
                               input logic [ame_pkg::DATA_W-1:0] ival);
    logic [ame_pkg::DATA_W-1:0] m;
    logic [ame_pkg::DATA_W-1:0] ua;
    logic [ame_pkg::DATA_W-1:0] ub;
    logic [ame_pkg::DATA_W-1:0] q;
    logic [ame_pkg::ADDR_W-1:0] nxt;
    logic                       stop_now;
    exec_result_t               r;
    r.ovalid = 1'b0;
    r.oval   = '0;
    if (!halted_m) begin
      m        = mem_m[a1];
      nxt      = pc_m + ame_pkg::INSTR_LEN_2;
      stop_now = 1'b0;
      case (op)
        ame_pkg::OP_ADD: acc_m = acc_m + m;
        ame_pkg::OP_SUB: acc_m = acc_m - m;
        ame_pkg::OP_MUL: acc_m = acc_m * m;
        ame_pkg::OP_DIV: begin
          if (m == '0) begin
            stop_now = 1'b1;
            cause_m  = ame_pkg::CAUSE_DIVZERO;
          end else begin
            // divide magnitudes, then restore the sign
            ua = acc_m[ame_pkg::DATA_W-1] ? 32'd0 - acc_m : acc_m;
            ub = m[ame_pkg::DATA_W-1] ? 32'd0 - m : m;
            q  = ua / ub;
            if (acc_m[ame_pkg::DATA_W-1] ^ m[ame_pkg::DATA_W-1]) q = 32'd0 - q;
            acc_m = q;
          end
        end
        ame_pkg::OP_JMP:  nxt = a1;
        ame_pkg::OP_JMPN: if (acc_m[ame_pkg::DATA_W-1]) nxt = a1;
        ame_pkg::OP_JMPP: if (!acc_m[ame_pkg::DATA_W-1] && acc_m != '0) nxt = a1;
        ame_pkg::OP_JMPZ: if (acc_m == '0) nxt = a1;
        ame_pkg::OP_COPY: begin
          mem_m[a2] = m;
          nxt = pc_m + ame_pkg::INSTR_LEN_3;
        end
        ame_pkg::OP_LOAD:  acc_m = m;
        ame_pkg::OP_STORE: mem_m[a1] = acc_m;
        ame_pkg::OP_INPUT: mem_m[a1] = ival;
        ame_pkg::OP_OUTPUT: begin
          r.ovalid = 1'b1;
          r.oval   = m;
        end
        ame_pkg::OP_STOP: begin
          stop_now = 1'b1;
          cause_m  = ame_pkg::CAUSE_STOP;
        end
        default: begin
          stop_now = 1'b1;
          cause_m  = ame_pkg::CAUSE_INVALID;
        end
      endcase
      if (stop_now) halted_m = 1'b1;
      else pc_m = nxt;
    end
    r.next_pc = pc_m;
    r.halted  = halted_m;
    r.cause   = cause_m;
    r.acc     = acc_m;
    pending_results.insert(pending_results.size(), r);
  endtask

  // offers one instruction request and waits until it is taken
  task automatic send_instr(input logic [ame_pkg::OP_W-1:0] op,
                            input logic [ame_pkg::ADDR_W-1:0] a1,
                            input logic [ame_pkg::ADDR_W-1:0] a2,
                            input logic [ame_pkg::DATA_W-1:0] ival);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tdata  <= {ival, a2, a1, op};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    execute_model(op, a1, a2, ival);
    instr_count++;
    if (op == ame_pkg::OP_DIV) div_count++;
    if (op == ame_pkg::OP_JMP || op == ame_pkg::OP_JMPN || op == ame_pkg::OP_JMPP ||
        op == ame_pkg::OP_JMPZ) jump_count++;
  endtask

  // data word biased toward the signed extremes
  function automatic logic [ame_pkg::DATA_W-1:0] rand_word();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0001;
      4, 5: return 32'($signed($urandom_range(40)) - 20);
      default: return $urandom;
    endcase
  endfunction

  // operand address, mostly from a small pool so that words get reused
  function automatic logic [ame_pkg::ADDR_W-1:0] rand_addr();
    int pick;
    pick = $urandom_range(99);
    if (pick < 75) return ame_pkg::ADDR_W'($urandom_range(15));
    if (pick < 88) return ame_pkg::ADDR_W'($urandom_range(ame_pkg::MEM_WORDS_DEF - 1));
    return ($urandom_range(1) != 0) ? ame_pkg::ADDR_W'(ame_pkg::MEM_WORDS_DEF - 1) : '0;
  endfunction

  // loads, arithmetic wrap, signed division corners and output
  task automatic test_arith_corners();
    send_instr(ame_pkg::OP_INPUT, 10'd0, 10'd0, 32'h7FFF_FFFF);
    send_instr(ame_pkg::OP_INPUT, 10'd1023, 10'd1023, 32'h8000_0000);
    send_instr(ame_pkg::OP_INPUT, 10'd3, 10'd0, 32'hFFFF_FFFF);
    send_instr(ame_pkg::OP_INPUT, 10'd2, 10'd0, 32'd1);
    send_instr(ame_pkg::OP_INPUT, 10'd5, 10'd0, 32'd7);
    send_instr(ame_pkg::OP_LOAD, 10'd0, 10'd0, 32'd0);
    send_instr(ame_pkg::OP_ADD, 10'd2, 10'd0, 32'd0);
    // most negative divided by minus one
    send_instr(ame_pkg::OP_DIV, 10'd3, 10'd0, 32'd0);
    send_instr(ame_pkg::OP_SUB, 10'd2, 10'd0, 32'd0);
    send_instr(ame_pkg::OP_MUL, 10'd3, 10'd0, 32'd0);
    send_instr(ame_pkg::OP_DIV, 10'd5, 10'd0, 32'd0);
    send_instr(ame_pkg::OP_STORE, 10'd4, 10'd0, 32'd0);
    send_instr(ame_pkg::OP_OUTPUT, 10'd4, 10'd0, 32'd0);
    send_instr(ame_pkg::OP_OUTPUT, 10'd1023, 10'd0, 32'd0);
  endtask

  // jumps taken and not taken, copy, and counter wrap
  task automatic test_flow_corners();
    send_instr(ame_pkg::OP_JMPN, 10'h155, 10'd0, 32'd0);
    send_instr(ame_pkg::OP_JMPP, 10'h2AA, 10'd0, 32'd0);
    send_instr(ame_pkg::OP_COPY, 10'd1023, 10'd0, 32'd0);
    send_instr(ame_pkg::OP_COPY, 10'd2, 10'd1023, 32'd0);
    send_instr(ame_pkg::OP_LOAD, 10'd1023, 10'd0, 32'd0);
    send_instr(ame_pkg::OP_JMPZ, 10'd1023, 10'd0, 32'd0);
    send_instr(ame_pkg::OP_SUB, 10'd2, 10'd0, 32'd0);
    send_instr(ame_pkg::OP_JMPP, 10'd9, 10'd0, 32'd0);
    send_instr(ame_pkg::OP_JMPZ, 10'd1023, 10'd0, 32'd0);
    // pc wraps past the top of the address space
    send_instr(ame_pkg::OP_ADD, 10'd0, 10'd0, 32'd0);
    send_instr(ame_pkg::OP_JMPN, 10'd1022, 10'd0, 32'd0);
    send_instr(ame_pkg::OP_COPY, 10'd0, 10'd6, 32'd0);
    send_instr(ame_pkg::OP_JMP, 10'd0, 10'd0, 32'd0);
  endtask

  // random well-formed instruction streams that never halt
  task automatic run_random_programs(input int count, input int s_pct, input int r_pct);
    logic [ame_pkg::OP_W-1:0]   op;
    logic [ame_pkg::ADDR_W-1:0] a1;
    int                         pick;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 18) op = ame_pkg::OP_INPUT;
      else if (pick < 28) op = ame_pkg::OP_LOAD;
      else if (pick < 37) op = ame_pkg::OP_ADD;
      else if (pick < 45) op = ame_pkg::OP_SUB;
      else if (pick < 52) op = ame_pkg::OP_MUL;
      else if (pick < 60) op = ame_pkg::OP_DIV;
      else if (pick < 68) op = ame_pkg::OP_STORE;
      else if (pick < 76) op = ame_pkg::OP_COPY;
      else if (pick < 84) op = ame_pkg::OP_OUTPUT;
      else if (pick < 88) op = ame_pkg::OP_JMP;
      else if (pick < 92) op = ame_pkg::OP_JMPN;
      else if (pick < 96) op = ame_pkg::OP_JMPP;
      else op = ame_pkg::OP_JMPZ;
      a1 = rand_addr();
      // keep the machine running: no divide by a zero word
      if (op == ame_pkg::OP_DIV && mem_m[a1] == '0) op = ame_pkg::OP_LOAD;
      send_instr(op, a1, rand_addr(), rand_word());
    end
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req_cnt++;
    run_random_programs(30, 0, 0);
  endtask

  // one halt cause per run, then requests against the held state
  task automatic test_halt();
    int how;
    how = $urandom_range(3);
    case (how)
      HALT_BY_STOP: begin
        halt_name = "stop";
        send_instr(ame_pkg::OP_STOP, rand_addr(), rand_addr(), rand_word());
      end
      HALT_BY_DIVZERO: begin
        halt_name = "divide by zero";
        send_instr(ame_pkg::OP_INPUT, 10'd7, 10'd0, 32'd0);
        send_instr(ame_pkg::OP_DIV, 10'd7, 10'd0, 32'd0);
      end
      HALT_BY_BAD_LOW: begin
        halt_name = "invalid opcode low";
        send_instr(OP_BAD_LOW, rand_addr(), rand_addr(), rand_word());
      end
      default: begin
        halt_name = "invalid opcode high";
        send_instr(OP_BAD_HIGH, rand_addr(), rand_addr(), rand_word());
      end
    endcase
    send_instr(ame_pkg::OP_OUTPUT, 10'd0, 10'd0, 32'd0);
    send_instr(ame_pkg::OP_INPUT, 10'd0, 10'd0, 32'h1234_5678);
    send_instr(ame_pkg::OP_ADD, 10'd0, 10'd0, 32'd0);
    send_instr(ame_pkg::OP_JMP, 10'd512, 10'd0, 32'd0);
    send_instr(ame_pkg::OP_STOP, 10'd0, 10'd0, 32'd0);
    send_instr(ame_pkg::OP_OUTPUT, 10'd0, 10'd0, 32'd0);
  endtask

  // receiver: random idling plus the long hold-off on request
  always @(posedge clk) begin
    int hold_seen;
    int hold_left;
    if (hold_req_cnt != hold_seen) begin
      hold_seen = hold_req_cnt;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic void check_field(input string name,
                                      input logic [ame_pkg::DATA_W-1:0] want,
                                      input logic [ame_pkg::DATA_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_count++;
    end
  endfunction

  // compares each accepted result request with the oldest prediction
  always @(posedge clk) begin
    exec_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result request with no prediction pending: %0h", out_tdata);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("next_pc", 32'(want.next_pc), 32'(out_tdata[9:0]));
        check_field("halted", 32'(want.halted), 32'(out_tdata[10]));
        check_field("halt_cause", 32'(want.cause), 32'(out_tdata[12:11]));
        check_field("output_valid", 32'(want.ovalid), 32'(out_tdata[13]));
        check_field("output_value", want.oval, out_tdata[45:14]);
        check_field("accumulator_value", want.acc, out_tdata[77:46]);
        result_count++;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    int quiet;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
    else quiet++;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", quiet);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    acc_m    = '0;
    pc_m     = '0;
    halted_m = 1'b0;
    cause_m  = ame_pkg::CAUSE_NONE;
    foreach (mem_m[i]) mem_m[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 24;
    recv_idle_pct = 66;
    test_arith_corners();
    test_flow_corners();
    run_random_programs(500, 24, 66);
    run_random_programs(500, 66, 24);
    test_backpressure();
    run_random_programs(100, 0, 0);
    test_halt();
    in_tvalid <= 1'b0;

    // drain, then allow for the block's own latency
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d predicted results never arrived", pending_results.size());
      err_count++;
    end

    $display("ran %0d instructions (%0d divides, %0d jumps), checked %0d results",
             instr_count, div_count, jump_count, result_count);
    $display("idle mixes on both sides, one long receiver hold-off, halted by %s",
             halt_name);
    if (err_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
